// File: hw/rtl/lcws_pkg.sv
package lcws_pkg;

  // Window sizes and trim
  localparam int LONG_DEPTH     = 64;
  localparam int SHORT_DEPTH    = 8;
  localparam int TRIM_EACH_SIDE = 2;

  // Field widths
  localparam int RAW_W      = 24;
  localparam int NET_W      = RAW_W + 1;
  localparam int TIME_W     = 32;
  localparam int CPK_W      = 32;
  localparam int MS_W       = 16;
  localparam int WT_W       = 48;
  localparam int SPR_W      = 47;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Ring addressing and counts
  localparam int LONG_AW   = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;
  localparam int SHORT_AW  = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
  localparam int MAX_DEPTH = (LONG_DEPTH > SHORT_DEPTH) ? LONG_DEPTH : SHORT_DEPTH;
  localparam int CW        = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W     = NET_W + CW;
  localparam int SQ_W      = 64;

  // Serial arithmetic units
  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 32;
  localparam int MUL_CNT_W  = $clog2(MUL_B_W);
  localparam int ROOT_W     = 56;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQ_CNT_W   = $clog2(ROOT_W);
  localparam int NUM_W      = 57;
  localparam int DEN_W      = 40;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int FRAC_SHIFT = 24;
  localparam int FRAC_PAD   = RAD_W - SQ_W;

  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [NUM_W-1:0] NEG_MAG = NUM_W'(48'h8000_0000_0000);

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TARE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPK      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 8'd3;

  localparam logic [RAW_W-1:0] TARE_RESET     = '0;
  localparam logic [CPK_W-1:0] CPK_RESET      = 32'd256;
  localparam logic [MS_W-1:0]  STALE_RESET    = 16'd10000;
  localparam logic [MS_W-1:0]  INTERVAL_RESET = 16'd5000;

  typedef struct packed {
    logic clear;
    logic push;
    logic start;
    logic sel_long;
  } win_ctl_t;

  typedef struct packed {
    logic          done;
    logic [CW-1:0] long_fill;
    logic [CW-1:0] trim_cnt;
  } win_stat_t;

endpackage

// File: hw/rtl/lcws_ram.sv
module lcws_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/lcws_mul.sv
module lcws_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lcws_pkg::MUL_A_W-1:0] a,
  input  logic [lcws_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [lcws_pkg::MUL_A_W-1:0] p
);
  import lcws_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   ma;
  logic [MUL_B_W-1:0]   mb;
  logic [MUL_A_W-1:0]   acc;

  // Shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MUL_CNT_W'(MUL_B_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a;
      mb  <= b;
      acc <= '0;
    end else if (busy) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma <= {ma[MUL_A_W-2:0], 1'b0};
      mb <= {1'b0, mb[MUL_B_W-1:1]};
    end
  end

  assign p = acc;
endmodule

// File: hw/rtl/lcws_div.sv
module lcws_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lcws_pkg::NUM_W-1:0] num,
  input  logic [lcws_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [lcws_pkg::NUM_W-1:0] quo
);
  import lcws_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     q;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dv;
  logic [DEN_W:0]       trial;
  logic                 fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, q[NUM_W-1]};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(NUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, dv}) : DEN_W'(trial);
      q   <= {q[NUM_W-2:0], fits};
    end
  end

  assign quo = q;
endmodule

// File: hw/rtl/lcws_sqrt.sv
module lcws_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lcws_pkg::SQ_W-1:0]   d,
  output logic                       done,
  output logic [lcws_pkg::ROOT_W-1:0] root
);
  import lcws_pkg::*;

  logic                busy;
  logic [SQ_CNT_W-1:0] cnt;
  logic [RAD_W-1:0]    rad;
  logic [ROOT_W+1:0]   rem;
  logic [ROOT_W+3:0]   r2;
  logic [ROOT_W+3:0]   tst;
  logic                fits;

  // Radicand is d scaled by 2^48; two radicand bits enter per cycle
  assign r2   = {rem, rad[RAD_W-1:RAD_W-2]};
  assign tst  = {2'b00, root, 2'b01};
  assign fits = r2 >= tst;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == SQ_CNT_W'(ROOT_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQ_CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {d, {FRAC_PAD{1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (ROOT_W + 2)'(r2 - tst) : (ROOT_W + 2)'(r2);
      root <= {root[ROOT_W-2:0], fits};
    end
  end
endmodule

// File: hw/rtl/lcws_window.sv
module lcws_window (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lcws_pkg::win_ctl_t                   ctl,
  input  logic signed [lcws_pkg::NET_W-1:0]    push_data,
  output lcws_pkg::win_stat_t                  stat,
  output logic signed [lcws_pkg::NET_W-1:0]    median,
  output logic signed [lcws_pkg::SUM_W-1:0]    sum,
  output logic signed [lcws_pkg::SUM_W-1:0]    tsum,
  output logic [lcws_pkg::SQ_W-1:0]            sumsq
);
  import lcws_pkg::*;

  localparam logic [2:0] W_IDLE    = 3'd0;
  localparam logic [2:0] W_FETCH   = 3'd1;
  localparam logic [2:0] W_SWEEP   = 3'd2;
  localparam logic [2:0] W_SQ_GO   = 3'd3;
  localparam logic [2:0] W_SQ_WAIT = 3'd4;

  logic [2:0]             state;
  logic                   sel;
  logic                   done_r;
  logic [LONG_AW-1:0]     long_wpos;
  logic [SHORT_AW-1:0]    short_wpos;
  logic [CW-1:0]          long_fill;
  logic [CW-1:0]          short_fill;
  logic [CW-1:0]          n;
  logic [CW-1:0]          i;
  logic [CW-1:0]          j;
  logic [CW-1:0]          rank;
  logic signed [NET_W-1:0] cand;

  logic [LONG_AW-1:0]     long_raddr;
  logic [SHORT_AW-1:0]    short_raddr;
  logic [NET_W-1:0]       long_rdata;
  logic [NET_W-1:0]       short_rdata;
  logic signed [NET_W-1:0] rd;
  logic [CW-1:0]          jd;
  logic                   less;
  logic                   trim_on;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [NET_W-1:0]       cabs;
  logic                   mul_done;
  logic [MUL_A_W-1:0]     mul_p;

  assign long_raddr  = (state == W_FETCH) ? i[LONG_AW-1:0] : j[LONG_AW-1:0];
  assign short_raddr = (state == W_FETCH) ? i[SHORT_AW-1:0] : j[SHORT_AW-1:0];

  lcws_ram #(.WIDTH(NET_W), .DEPTH(LONG_DEPTH)) u_long (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (long_wpos),
    .wdata (push_data),
    .raddr (long_raddr),
    .rdata (long_rdata)
  );

  lcws_ram #(.WIDTH(NET_W), .DEPTH(SHORT_DEPTH)) u_short (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (short_wpos),
    .wdata (push_data),
    .raddr (short_raddr),
    .rdata (short_rdata)
  );

  assign rd = $signed(sel ? long_rdata : short_rdata);

  // Stable rank: ties broken by ring position
  assign jd   = j - 1'b1;
  assign less = (rd < cand) || ((rd == cand) && (jd < i));

  assign trim_on = long_fill > CW'(2 * TRIM_EACH_SIDE);
  assign lo      = trim_on ? CW'(TRIM_EACH_SIDE) : '0;
  assign hi      = trim_on ? long_fill - CW'(TRIM_EACH_SIDE) : long_fill;
  assign cabs    = cand[NET_W-1] ? NET_W'(-cand) : NET_W'(cand);

  lcws_mul u_sq (
    .clk   (clk),
    .rst   (rst),
    .start (state == W_SQ_GO),
    .a     (MUL_A_W'(cabs)),
    .b     (MUL_B_W'(cabs)),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Ring write side
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      long_wpos  <= '0;
      short_wpos <= '0;
      long_fill  <= '0;
      short_fill <= '0;
    end else if (ctl.push) begin
      long_wpos  <= (long_wpos == LONG_AW'(LONG_DEPTH - 1)) ? '0 : long_wpos + 1'b1;
      short_wpos <= (short_wpos == SHORT_AW'(SHORT_DEPTH - 1)) ? '0 : short_wpos + 1'b1;
      if (long_fill < CW'(LONG_DEPTH)) begin
        long_fill <= long_fill + 1'b1;
      end
      if (short_fill < CW'(SHORT_DEPTH)) begin
        short_fill <= short_fill + 1'b1;
      end
    end
  end

  // Rank sweep: one candidate at a time against every entry
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= W_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (state == W_SQ_WAIT) && mul_done && (i == n - 1'b1);
      case (state)
        W_IDLE: begin
          if (ctl.start) begin
            state <= W_FETCH;
          end
        end
        W_FETCH: begin
          state <= W_SWEEP;
        end
        W_SWEEP: begin
          if (j == n) begin
            state <= W_SQ_GO;
          end
        end
        W_SQ_GO: begin
          state <= W_SQ_WAIT;
        end
        W_SQ_WAIT: begin
          if (mul_done) begin
            if (i == n - 1'b1) begin
              state <= W_IDLE;
            end else begin
              state <= W_FETCH;
            end
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      W_IDLE: begin
        if (ctl.start) begin
          sel   <= ctl.sel_long;
          n     <= ctl.sel_long ? long_fill : short_fill;
          i     <= '0;
          sum   <= '0;
          tsum  <= '0;
          sumsq <= '0;
        end
      end
      W_FETCH: begin
        j    <= '0;
        rank <= '0;
      end
      W_SWEEP: begin
        if (j == '0) begin
          cand <= rd;
        end else if (less) begin
          rank <= rank + 1'b1;
        end
        j <= j + 1'b1;
      end
      W_SQ_GO: begin
        if (rank == (n >> 1)) begin
          median <= cand;
        end
        if ((rank >= lo) && (rank < hi)) begin
          tsum <= tsum + SUM_W'(cand);
        end
        sum <= sum + SUM_W'(cand);
      end
      W_SQ_WAIT: begin
        if (mul_done) begin
          sumsq <= sumsq + mul_p;
          i     <= i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.done      = done_r;
    stat.long_fill = long_fill;
    stat.trim_cnt  = hi - lo;
  end
endmodule

// File: hw/rtl/load_cell_window_statistics_top.sv
// Load-cell window statistics.
// Input channel item_valid/item_ready carries operation (0 poll, 1 sample),
// raw_sample and now_ms. Each transaction yields exactly one report on
// report_valid/report_ready: flags, last raw count and four weights in
// fixed point with 24 fraction bits, the spread unsigned, the rest signed.
// Configuration channel cfg_valid/cfg_ready writes register cfg_index
// (0 tare, 1 counts per kg, 2 stale timeout, 3 stats interval) with
// cfg_data; any write of a listed register empties both windows and zeroes
// the fast weight. Other indexes are taken and ignored.
// One item at a time. A poll or a faulted sample goes straight to the
// report state. A good sample with nonzero counts per kg ranks the short
// ring and scales through a serial multiply and divide; with stats due,
// the long ring ranks the same way, then two multiplies, a root and three
// scalings follow. With zero counts per kg, due stats are zeroed and marked
// invalid instead. The rank sweep, one ring read per cycle, sets the rate.
// Reset clears rings, flags and held results, and loads default registers.
// A stalled report holds the block in its final state; nothing is dropped.
module load_cell_window_statistics_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 operation,
  input  logic signed [lcws_pkg::RAW_W-1:0]    raw_sample,
  input  logic [lcws_pkg::TIME_W-1:0]          now_ms,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lcws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcws_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 report_valid,
  input  logic                                 report_ready,
  output logic                                 sensor_ready,
  output logic                                 result_valid,
  output logic signed [lcws_pkg::RAW_W-1:0]    last_raw,
  output logic signed [lcws_pkg::WT_W-1:0]     fast_weight,
  output logic signed [lcws_pkg::WT_W-1:0]     median_weight,
  output logic [lcws_pkg::SPR_W-1:0]           weight_spread,
  output logic signed [lcws_pkg::WT_W-1:0]     trimmed_mean_weight
);
  import lcws_pkg::*;

  localparam logic [4:0] S_IDLE        = 5'd0;
  localparam logic [4:0] S_RANK_S_GO   = 5'd1;
  localparam logic [4:0] S_RANK_S_WAIT = 5'd2;
  localparam logic [4:0] S_STATS       = 5'd3;
  localparam logic [4:0] S_RANK_L_GO   = 5'd4;
  localparam logic [4:0] S_RANK_L_WAIT = 5'd5;
  localparam logic [4:0] S_NSQ_GO      = 5'd6;
  localparam logic [4:0] S_NSQ_WAIT    = 5'd7;
  localparam logic [4:0] S_SSQ_GO      = 5'd8;
  localparam logic [4:0] S_SSQ_WAIT    = 5'd9;
  localparam logic [4:0] S_SQRT_GO     = 5'd10;
  localparam logic [4:0] S_SQRT_WAIT   = 5'd11;
  localparam logic [4:0] S_DEN_GO      = 5'd12;
  localparam logic [4:0] S_DEN_WAIT    = 5'd13;
  localparam logic [4:0] S_DIV_GO      = 5'd14;
  localparam logic [4:0] S_DIV_WAIT    = 5'd15;
  localparam logic [4:0] S_OUT         = 5'd16;

  localparam logic [1:0] J_FAST = 2'd0;
  localparam logic [1:0] J_MED  = 2'd1;
  localparam logic [1:0] J_SPR  = 2'd2;
  localparam logic [1:0] J_TRIM = 2'd3;

  logic [4:0] state;
  logic [1:0] job;

  // Configuration registers
  logic signed [RAW_W-1:0] tare;
  logic signed [CPK_W-1:0] cpk;
  logic [MS_W-1:0]         stale_to;
  logic [MS_W-1:0]         interval;

  // Held state
  logic [TIME_W-1:0]       last_sample_time;
  logic [TIME_W-1:0]       last_stats_time;
  logic [TIME_W-1:0]       now_r;
  logic                    due;
  logic                    valid_flag;
  logic                    ready_flag;
  logic signed [RAW_W-1:0] held_raw;
  logic [WT_W-1:0]         held_fast;
  logic [WT_W-1:0]         held_med;
  logic [SPR_W-1:0]        held_spread;
  logic [WT_W-1:0]         held_trim;

  // Datapath registers
  logic [SQ_W-1:0]         dvar;
  logic [ROOT_W-1:0]       root_r;
  logic [DEN_W-1:0]        den_r;

  logic                    item_acc;
  logic                    cfg_acc;
  logic                    cfg_hit;
  logic                    fault;
  logic                    stale;
  logic                    cpk_zero;
  logic signed [NET_W-1:0] net;

  win_ctl_t                win_ctl;
  win_stat_t               win_stat;
  logic signed [NET_W-1:0] win_median;
  logic signed [SUM_W-1:0] win_sum;
  logic signed [SUM_W-1:0] win_tsum;
  logic [SQ_W-1:0]         win_sumsq;

  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic                    mul_done;
  logic [MUL_A_W-1:0]      mul_p;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;
  logic [NUM_W-1:0]        div_num;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;

  logic signed [SUM_W-1:0] sel_val;
  logic [SUM_W-1:0]        nmag;
  logic [SUM_W-1:0]        smag;
  logic [CW-1:0]           cnt_sel;
  logic [CPK_W-1:0]        fmag;
  logic                    neg;
  logic [NUM_W-1:0]        mag_sat;
  logic [WT_W-1:0]         packed_wt;
  logic [SPR_W-1:0]        packed_spr;

  assign item_ready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state == S_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign cfg_hit    = cfg_acc && ((cfg_index == REG_TARE) || (cfg_index == REG_CPK) ||
                      (cfg_index == REG_STALE) || (cfg_index == REG_INTERVAL));

  assign fault    = &raw_sample;
  assign stale    = (last_sample_time == '0) ||
                    ((now_ms - last_sample_time) >= TIME_W'(stale_to));
  assign cpk_zero = (cpk == '0);
  assign net      = NET_W'(raw_sample) - NET_W'(tare);

  always_comb begin
    win_ctl.clear    = cfg_hit;
    win_ctl.push     = item_acc && operation && !fault;
    win_ctl.start    = (state == S_RANK_S_GO) || (state == S_RANK_L_GO);
    win_ctl.sel_long = (state == S_RANK_L_GO);
  end

  lcws_window u_window (
    .clk       (clk),
    .rst       (rst),
    .ctl       (win_ctl),
    .push_data (net),
    .stat      (win_stat),
    .median    (win_median),
    .sum       (win_sum),
    .tsum      (win_tsum),
    .sumsq     (win_sumsq)
  );

  // Scaling operand selection
  always_comb begin
    case (job)
      J_FAST, J_MED: begin
        sel_val = SUM_W'(win_median);
        cnt_sel = CW'(1);
      end
      J_TRIM: begin
        sel_val = win_tsum;
        cnt_sel = win_stat.trim_cnt;
      end
      default: begin
        sel_val = '0;
        cnt_sel = win_stat.long_fill;
      end
    endcase
  end

  assign nmag = sel_val[SUM_W-1] ? SUM_W'(-sel_val) : SUM_W'(sel_val);
  assign smag = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);
  assign fmag = cpk[CPK_W-1] ? CPK_W'(-cpk) : CPK_W'(cpk);
  assign neg  = sel_val[SUM_W-1] ^ cpk[CPK_W-1];

  always_comb begin
    case (state)
      S_NSQ_GO: begin
        mul_a = win_sumsq;
        mul_b = MUL_B_W'(win_stat.long_fill);
      end
      S_SSQ_GO: begin
        mul_a = MUL_A_W'(smag);
        mul_b = MUL_B_W'(smag);
      end
      default: begin
        mul_a = MUL_A_W'(fmag);
        mul_b = MUL_B_W'(cnt_sel);
      end
    endcase
  end

  lcws_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_NSQ_GO) || (state == S_SSQ_GO) || (state == S_DEN_GO)),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Round half away from zero: add half the divisor to the magnitude
  assign div_num = (job == J_SPR) ?
                   NUM_W'(root_r) + NUM_W'(den_r >> 1) :
                   NUM_W'({nmag, {FRAC_SHIFT{1'b0}}}) + NUM_W'(den_r >> 1);

  lcws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  lcws_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SQRT_GO),
    .d     (dvar),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // Saturate the quotient into the 48-bit signed or 47-bit unsigned result
  always_comb begin
    if (neg) begin
      mag_sat   = (div_quo > NEG_MAG) ? NEG_MAG : div_quo;
      packed_wt = WT_W'(-mag_sat);
    end else begin
      mag_sat   = (div_quo > POS_MAX) ? POS_MAX : div_quo;
      packed_wt = WT_W'(mag_sat);
    end
    packed_spr = (div_quo > POS_MAX) ? SPR_W'(POS_MAX) : SPR_W'(div_quo);
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      job              <= J_FAST;
      tare             <= TARE_RESET;
      cpk              <= CPK_RESET;
      stale_to         <= STALE_RESET;
      interval         <= INTERVAL_RESET;
      last_sample_time <= '0;
      last_stats_time  <= '0;
      valid_flag       <= 1'b0;
      ready_flag       <= 1'b0;
      held_raw         <= '0;
      held_fast        <= '0;
      held_med         <= '0;
      held_spread      <= '0;
      held_trim        <= '0;
      report_valid     <= 1'b0;
    end else begin
      // Drop the report once taken, unless the next one loads in its place
      if (report_valid && report_ready && (state != S_OUT)) begin
        report_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            case (cfg_index)
              REG_TARE:     tare     <= cfg_data[RAW_W-1:0];
              REG_CPK:      cpk      <= cfg_data[CPK_W-1:0];
              REG_STALE:    stale_to <= cfg_data[MS_W-1:0];
              REG_INTERVAL: interval <= cfg_data[MS_W-1:0];
              default: begin
              end
            endcase
            if (cfg_hit) begin
              held_fast <= '0;
            end
          end else if (item_acc) begin
            if (!operation) begin
              if (stale) begin
                valid_flag <= 1'b0;
                ready_flag <= 1'b0;
              end
              state <= S_OUT;
            end else if (fault) begin
              valid_flag <= 1'b0;
              ready_flag <= 1'b0;
              state      <= S_OUT;
            end else begin
              held_raw         <= raw_sample;
              ready_flag       <= 1'b1;
              last_sample_time <= now_ms;
              now_r            <= now_ms;
              due              <= ((now_ms - last_stats_time) >= TIME_W'(interval)) ||
                                  !valid_flag;
              state            <= cpk_zero ? S_STATS : S_RANK_S_GO;
            end
          end
        end
        S_RANK_S_GO: begin
          state <= S_RANK_S_WAIT;
        end
        S_RANK_S_WAIT: begin
          if (win_stat.done) begin
            job   <= J_FAST;
            state <= S_DEN_GO;
          end
        end
        S_STATS: begin
          if (!due) begin
            state <= S_OUT;
          end else begin
            last_stats_time <= now_r;
            if (cpk_zero) begin
              held_med    <= '0;
              held_spread <= '0;
              held_trim   <= '0;
              valid_flag  <= 1'b0;
              state       <= S_OUT;
            end else begin
              state <= S_RANK_L_GO;
            end
          end
        end
        S_RANK_L_GO: begin
          state <= S_RANK_L_WAIT;
        end
        S_RANK_L_WAIT: begin
          if (win_stat.done) begin
            state <= S_NSQ_GO;
          end
        end
        S_NSQ_GO: begin
          state <= S_NSQ_WAIT;
        end
        S_NSQ_WAIT: begin
          if (mul_done) begin
            dvar  <= mul_p;
            state <= S_SSQ_GO;
          end
        end
        S_SSQ_GO: begin
          state <= S_SSQ_WAIT;
        end
        S_SSQ_WAIT: begin
          if (mul_done) begin
            dvar  <= dvar - mul_p;
            state <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: begin
          state <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (sqrt_done) begin
            root_r <= sqrt_root;
            job    <= J_MED;
            state  <= S_DEN_GO;
          end
        end
        S_DEN_GO: begin
          state <= S_DEN_WAIT;
        end
        S_DEN_WAIT: begin
          if (mul_done) begin
            den_r <= mul_p[DEN_W-1:0];
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (job)
              J_FAST: begin
                held_fast <= packed_wt;
                state     <= S_STATS;
              end
              J_MED: begin
                held_med <= packed_wt;
                job      <= J_SPR;
                state    <= S_DEN_GO;
              end
              J_SPR: begin
                held_spread <= packed_spr;
                job         <= J_TRIM;
                state       <= S_DEN_GO;
              end
              default: begin
                held_trim  <= packed_wt;
                valid_flag <= 1'b1;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          // Hold here while the previous report is still waiting
          if (!report_valid || report_ready) begin
            report_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Report register
  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!report_valid || report_ready)) begin
      sensor_ready        <= ready_flag;
      result_valid        <= valid_flag;
      last_raw            <= held_raw;
      fast_weight         <= held_fast;
      median_weight       <= held_med;
      weight_spread       <= held_spread;
      trimmed_mean_weight <= held_trim;
    end
  end

  a_poll_reports: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && !operation) |=> (state == S_OUT))
    else $error("poll transaction did not go straight to report");

  a_valid_needs_ready: assert property (@(posedge clk) disable iff (rst)
    valid_flag |-> ready_flag)
    else $error("result valid without a ready sensor");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    win_stat.long_fill <= CW'(LONG_DEPTH))
    else $error("long ring fill beyond depth");
endmodule

// File: dv/tb_load_cell_window_statistics_top.sv
`timescale 1ns / 1ps

module tb_load_cell_window_statistics_top;
  import lcws_pkg::*;

  localparam int          PERIOD_NS   = 10;
  localparam int          RESET_CYC   = 7;
  localparam int          DRAIN_CYC   = 4;
  localparam int          TAIL_CYC    = 40;
  localparam longint      CYCLE_LIMIT = 8_000_000;
  localparam logic [47:0] POS_SAT     = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_SAT     = 48'h8000_0000_0000;

  typedef enum logic { OP_POLL = 1'b0, OP_SAMPLE = 1'b1 } op_e;
  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_e;

  typedef struct {
    logic              sready;
    logic              rvalid;
    logic [RAW_W-1:0]  raw;
    logic [WT_W-1:0]   fast;
    logic [WT_W-1:0]   med;
    logic [SPR_W-1:0]  spr;
    logic [WT_W-1:0]   tmean;
  } weigh_report_t;

  typedef struct {
    row_kind_e           kind;
    op_e                 op;
    logic [RAW_W-1:0]    raw;
    logic [TIME_W-1:0]   now;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    bit                  typed;
    weigh_report_t       rep;
  } stim_row_t;

  // DUT ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  logic                   operation = 1'b0;
  logic [RAW_W-1:0]       raw_sample = '0;
  logic [TIME_W-1:0]      now_ms = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   report_valid;
  logic                   report_ready = 1'b0;
  logic                   sensor_ready;
  logic                   result_valid;
  logic [RAW_W-1:0]       last_raw;
  logic [WT_W-1:0]        fast_weight;
  logic [WT_W-1:0]        median_weight;
  logic [SPR_W-1:0]       weight_spread;
  logic [WT_W-1:0]        trimmed_mean_weight;

  load_cell_window_statistics_top DUT (
    .clk, .rst, .item_valid, .item_ready, .operation, .raw_sample, .now_ms,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .report_valid, .report_ready,
    .sensor_ready, .result_valid, .last_raw, .fast_weight, .median_weight,
    .weight_spread, .trimmed_mean_weight
  );

  always begin
    #(PERIOD_NS / 2) clk = 1'b1;
    #(PERIOD_NS / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Scale model state: windows, timers, held report, registers
  // ---------------------------------------------------------------------
  int              long_win [LONG_DEPTH];
  int              short_win[SHORT_DEPTH];
  int              long_pos, long_cnt, short_pos, short_cnt;
  logic [31:0]     sample_stamp, stats_stamp;
  weigh_report_t   held;
  int              tare_cnt;
  longint          cal_factor;
  logic [15:0]     stale_ms, interval_ms;
  int              rank_buf[LONG_DEPTH];

  weigh_report_t   pending_reports[$];
  int              errors = 0;
  int              tx_idle_pct, rx_stall_pct;
  longint          cycle_cnt = 0;

  function automatic void empty_windows();
    for (int i = 0; i < LONG_DEPTH; i++) long_win[i] = 0;
    for (int i = 0; i < SHORT_DEPTH; i++) short_win[i] = 0;
    long_pos = 0; long_cnt = 0; short_pos = 0; short_cnt = 0;
    held.fast = '0;
  endfunction

  // Insertion sort of the first n entries of rank_buf
  function automatic void rank_prefix(int n);
    int v, j;
    for (int i = 1; i < n; i++) begin
      v = rank_buf[i];
      j = i;
      while (j > 0 && rank_buf[j-1] > v) begin
        rank_buf[j] = rank_buf[j-1];
        j--;
      end
      rank_buf[j] = v;
    end
  endfunction

  function automatic longint unsigned factor_mag();
    return (cal_factor < 0) ? longint'(-cal_factor) : longint'(cal_factor);
  endfunction

  // Counts to kilograms: round(num * 2^24 / (cnt * factor)), saturated
  function automatic logic [WT_W-1:0] counts_to_kg(longint num, longint unsigned cnt);
    longint unsigned nmag, den, q;
    bit neg;
    nmag = (num < 0) ? longint'(-num) : longint'(num);
    den  = cnt * factor_mag();
    if (den == 0) return '0;
    q   = ((nmag << 24) + den / 2) / den;
    neg = (num < 0) != (cal_factor < 0);
    if (!neg) return (q > POS_SAT) ? POS_SAT : q[47:0];
    if (q > NEG_SAT) q = NEG_SAT;
    return 48'(64'd0 - q);
  endfunction

  function automatic logic [SPR_W-1:0] spread_to_kg(longint unsigned d, longint unsigned n);
    logic [111:0] rad, sq;
    logic [55:0]  root, trial;
    longint unsigned den, q;
    rad  = {d, 48'd0};
    root = '0;
    for (int k = 55; k >= 0; k--) begin
      trial = root | (56'd1 << k);
      sq = 112'(trial) * 112'(trial);
      if (sq <= rad) root = trial;
    end
    den = n * factor_mag();
    if (den == 0) return '0;
    q = (64'(root) + den / 2) / den;
    return (q > POS_SAT) ? SPR_W'(POS_SAT) : q[46:0];
  endfunction

  function automatic void refresh_stats();
    int n, lo, hi;
    longint sum, tsum, x;
    longint unsigned sumsq, smag, d;
    n = long_cnt;
    if (cal_factor == 0 || n == 0) begin
      held.med = '0; held.spr = '0; held.tmean = '0;
      held.rvalid = (cal_factor != 0);
      return;
    end
    for (int i = 0; i < n; i++) rank_buf[i] = long_win[i];
    rank_prefix(n);
    sum = 0; sumsq = 0; tsum = 0;
    for (int i = 0; i < n; i++) begin
      x = rank_buf[i];
      sum += x;
      sumsq += longint'(x * x);
    end
    smag = (sum < 0) ? longint'(-sum) : longint'(sum);
    d = longint'(n) * sumsq - smag * smag;
    lo = 0; hi = n;
    if (n > 2 * TRIM_EACH_SIDE) begin
      lo = TRIM_EACH_SIDE;
      hi = n - TRIM_EACH_SIDE;
    end
    for (int i = lo; i < hi; i++) tsum += rank_buf[i];
    held.med    = counts_to_kg(rank_buf[n/2], 1);
    held.spr    = spread_to_kg(d, n);
    held.tmean  = counts_to_kg(tsum, hi - lo);
    held.rvalid = 1'b1;
  endfunction

  function automatic weigh_report_t weigh_step(op_e op, logic [RAW_W-1:0] raw,
                                               logic [31:0] now);
    int raw_i, net;
    logic [31:0] since_sample, since_stats;
    raw_i = $signed(raw);
    since_sample = now - sample_stamp;
    if (op == OP_POLL) begin
      if (sample_stamp == 0 || since_sample >= 32'(stale_ms)) begin
        held.rvalid = 1'b0; held.sready = 1'b0;
      end
    end else if (raw == '1) begin
      // wiring fault: line stuck high
      held.rvalid = 1'b0; held.sready = 1'b0;
    end else begin
      net = raw_i - tare_cnt;
      long_win[long_pos] = net;
      long_pos = (long_pos + 1 >= LONG_DEPTH) ? 0 : long_pos + 1;
      if (long_cnt < LONG_DEPTH) long_cnt++;
      short_win[short_pos] = net;
      short_pos = (short_pos + 1 >= SHORT_DEPTH) ? 0 : short_pos + 1;
      if (short_cnt < SHORT_DEPTH) short_cnt++;
      if (cal_factor != 0) begin
        for (int i = 0; i < short_cnt; i++) rank_buf[i] = short_win[i];
        rank_prefix(short_cnt);
        held.fast = counts_to_kg(rank_buf[short_cnt/2], 1);
      end
      held.raw = raw;
      held.sready = 1'b1;
      sample_stamp = now;
      since_stats = now - stats_stamp;
      if (since_stats >= 32'(interval_ms) || !held.rvalid) begin
        stats_stamp = now;
        refresh_stats();
      end
    end
    return held;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARE:     tare_cnt = $signed(data[RAW_W-1:0]);
      REG_CPK:      cal_factor = longint'($signed(data));
      REG_STALE:    stale_ms = data[MS_W-1:0];
      REG_INTERVAL: interval_ms = data[MS_W-1:0];
      default:      return;
    endcase
    empty_windows();
  endfunction

  function automatic void model_reset();
    empty_windows();
    sample_stamp = '0; stats_stamp = '0;
    held = '{default: '0};
    tare_cnt = 0; cal_factor = 256; stale_ms = 16'd10000; interval_ms = 16'd5000;
  endfunction

  // ---------------------------------------------------------------------
  // Transaction drivers
  // ---------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Drive one input transaction; hold valid across back-to-back items.
  // A typed row queues its hand-written report, else the model's.
  task automatic push_item(op_e op, logic [RAW_W-1:0] raw, logic [31:0] now,
                           bit typed, weigh_report_t typed_rep);
    weigh_report_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    raw_sample <= raw;
    now_ms     <= now;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = weigh_step(op, raw, now);
    pending_reports.push_back(typed ? typed_rep : predicted);
  endtask

  // Registers change only with the block idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    item_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // Report side: random stall, compare against the oldest expectation
  // ---------------------------------------------------------------------
  weigh_report_t want;

  always @(posedge clk) begin
    report_ready <= ($urandom_range(99) >= rx_stall_pct);
    if (!rst && report_valid && report_ready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected report, expected none actual raw %h",
                 $time, last_raw);
      end else begin
        want = pending_reports.pop_front();
        check_field("sensor_ready", 48'(want.sready), 48'(sensor_ready));
        check_field("result_valid", 48'(want.rvalid), 48'(result_valid));
        check_field("last_raw", 48'(want.raw), 48'(last_raw));
        check_field("fast_weight", want.fast, fast_weight);
        check_field("median_weight", want.med, median_weight);
        check_field("weight_spread", 48'(want.spr), 48'(weight_spread));
        check_field("trimmed_mean_weight", want.tmean, trimmed_mean_weight);
      end
    end
  end

  // Hard stop on a hung handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_load_cell_window_statistics_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  stim_row_t directed[$];

  function automatic void add_item(op_e op, logic [RAW_W-1:0] raw, logic [31:0] now);
    stim_row_t r;
    r = '{kind: ROW_ITEM, op: op, raw: raw, now: now, idx: '0, data: '0,
          typed: 1'b0, rep: '{default: '0}};
    directed.push_back(r);
  endfunction

  function automatic void add_typed(op_e op, logic [RAW_W-1:0] raw, logic [31:0] now,
                                    weigh_report_t rep);
    add_item(op, raw, now);
    directed[$].typed = 1'b1;
    directed[$].rep   = rep;
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, op: OP_POLL, raw: '0, now: '0, idx: idx, data: data,
          typed: 1'b0, rep: '{default: '0}};
    directed.push_back(r);
  endfunction

  initial begin
    weigh_report_t        blank, full_pos;
    logic [RAW_W-1:0]     raw, center;
    logic [31:0]          clock_ms, now;
    logic [CFG_DATA_W-1:0] set_tare, set_cpk, set_stale, set_intv;
    op_e                  op;
    int                   seg_len, pick;

    blank    = '{default: '0};
    full_pos = '{sready: 1'b1, rvalid: 1'b1, raw: 24'h7FFFFF, fast: 48'h007F_FFFF_0000,
                 med: 48'h007F_FFFF_0000, spr: '0, tmean: 48'h007F_FFFF_0000};
    model_reset();
    tx_idle_pct  = 15;
    rx_stall_pct = 87;

    // poll before any sample, then a stuck-high line
    add_typed(OP_POLL, 24'd0, 32'd5, blank);
    add_typed(OP_SAMPLE, 24'hFFFFFF, 32'd100, blank);
    // largest sample with default scale: net * 2^16 exactly
    add_typed(OP_SAMPLE, 24'h7FFFFF, 32'd200, full_pos);
    // most negative sample: upper median stays the largest, stats not yet due
    full_pos.raw = 24'h800000;
    add_typed(OP_SAMPLE, 24'h800000, 32'd300, full_pos);
    add_typed(OP_POLL, 24'd0, 32'd400, full_pos);
    // stale after the default timeout
    full_pos.sready = 1'b0; full_pos.rvalid = 1'b0;
    add_typed(OP_POLL, 24'd0, 32'd10300, full_pos);
    // a sample stamped at time zero counts as never sampled
    add_item(OP_SAMPLE, 24'd0, 32'd0);
    add_item(OP_POLL, 24'd0, 32'd1);
    // timer wrap
    add_item(OP_SAMPLE, 24'd1000, 32'hFFFF_FF00);
    add_item(OP_SAMPLE, -24'sd1000, 32'h0000_0100);
    add_item(OP_SAMPLE, 24'd123456, 32'h0000_2000);
    add_cfg(8'd200, 32'hFFFF_FFFF);
    add_item(OP_SAMPLE, 24'd5, 32'h0000_3000);
    // uncalibrated: fast weight held, stats forced to zero and invalid
    add_cfg(REG_CPK, 32'd0);
    add_item(OP_SAMPLE, 24'd77, 32'h0000_9000);
    add_item(OP_SAMPLE, 24'd78, 32'h0000_9001);
    add_cfg(REG_CPK, 32'd256);
    add_cfg(REG_TARE, 32'h0080_0000);
    add_item(OP_SAMPLE, 24'h7FFFFF, 32'h0000_A000);
    add_item(OP_SAMPLE, 24'h800000, 32'h0000_A001);
    add_cfg(REG_STALE, 32'd0);
    add_item(OP_POLL, 24'd0, 32'h0000_A002);
    add_cfg(REG_INTERVAL, 32'd0);
    add_item(OP_SAMPLE, 24'd42, 32'h0000_A003);
    add_item(OP_SAMPLE, 24'd43, 32'h0000_A004);

    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_register(directed[i].idx, directed[i].data);
      else
        push_item(directed[i].op, directed[i].raw, directed[i].now,
                  directed[i].typed, directed[i].rep);
    end

    // Random segments, each with its own register setting
    clock_ms = 32'h0001_0000;
    for (int seg = 0; seg < 8; seg++) begin
      tx_idle_pct  = (seg < 3) ? 15 : (seg < 6) ? 87 : 0;
      rx_stall_pct = (seg < 3) ? 87 : (seg < 6) ? 15 : 0;
      set_tare  = $urandom;
      set_cpk   = $urandom;
      set_stale = $urandom_range(1, 65535);
      set_intv  = $urandom_range(1, 65535);
      case (seg)
        0: begin set_tare = 0; set_cpk = 256; set_stale = 10000; set_intv = 5000; end
        1: begin set_tare = 32'h0080_0000; set_cpk = 32'h7FFF_FFFF;
                 set_stale = 1; set_intv = 65535; end
        2: begin set_tare = 32'h007F_FFFF; set_cpk = 32'h8000_0000;
                 set_stale = 65535; set_intv = 1; end
        3: begin set_cpk = 0; set_stale = 0; set_intv = 0; end
        4: begin set_tare = $urandom_range(0, 4095); set_cpk = 1;
                 set_stale = 3000; set_intv = 0; end
        5: set_cpk = -32'sd256;
        7: begin set_tare = 0; set_cpk = 256; set_stale = 10000; set_intv = 5000; end
        default: ;
      endcase
      write_register(REG_TARE, set_tare);
      write_register(REG_CPK, set_cpk);
      write_register(REG_STALE, set_stale);
      write_register(REG_INTERVAL, set_intv);

      // segment 4 runs more items than the long window holds
      seg_len = (seg == 4) ? 70 : 8;
      center  = $urandom;
      for (int k = 0; k < seg_len; k++) begin
        if (seg == 5 && k == 6) begin
          item_valid <= 1'b0;
          wait_drained();
        end
        op = ($urandom_range(9) < 8) ? OP_SAMPLE : OP_POLL;
        pick = $urandom_range(99);
        if (pick < 8)       raw = '1;
        else if (pick < 20) raw = $urandom;
        else if (pick < 28) raw = ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
        else                raw = center + RAW_W'($urandom_range(0, 2000)) - 24'd1000;
        pick = $urandom_range(99);
        if (pick < 70)      clock_ms += $urandom_range(0, 3000);
        else if (pick < 90) clock_ms += $urandom_range(3000, 70000);
        else if (pick < 95) clock_ms = $urandom;
        else                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        now = ($urandom_range(49) == 0) ? 32'd0 : clock_ms;
        push_item(op, raw, now, 1'b0, blank);
      end
    end

    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0)
      $display("tb_load_cell_window_statistics_top: done, clean");
    else
      $display("tb_load_cell_window_statistics_top: done, errors");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lcws_pkg.sv
hw/rtl/lcws_ram.sv
hw/rtl/lcws_mul.sv
hw/rtl/lcws_div.sv
hw/rtl/lcws_sqrt.sv
hw/rtl/lcws_window.sv
hw/rtl/load_cell_window_statistics_top.sv
dv/tb_load_cell_window_statistics_top.sv
